@@ sv/sci_pkg.sv @@
// Shared constants, payload types and memory port types for the submesh index compactor.
`timescale 1ns / 1ps

package sci_pkg;

   localparam int VERTEX_CAPACITY = 65536;
   localparam int GENERATION_BITS = 16;
   localparam int ADDR_BITS       = $clog2(VERTEX_CAPACITY);
   localparam int INDEX_BITS      = 16;
   localparam int COUNT_BITS      = 17;

   typedef enum logic [1:0] {
      STATUS_REUSED    = 2'd0,
      STATUS_NEW       = 2'd1,
      STATUS_RANGE     = 2'd2,
      STATUS_EXHAUSTED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_LOOKUP = 2'b10
   } core_state_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] orig_index;
      logic                  last_of_submesh;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] new_index;
      status_type            status;
      logic [INDEX_BITS-1:0] vertex_to_copy;
      logic                  last;
   } rsp_payload_type;

   // One table entry: the generation tag and the remapped index live side by side.
   typedef struct packed {
      logic [GENERATION_BITS-1:0] tag;
      logic [INDEX_BITS-1:0]      value;
   } entry_type;

   typedef struct packed {
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      entry_type            wr_data;
   } mem_req_type;

endpackage

@@ sv/sci_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module sci_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sci_clear.sv @@
// Post-reset sweep that writes a zero tag into every table entry.
`timescale 1ns / 1ps

module sci_clear (
   input  logic                clock,
   input  logic                reset,
   output logic                busy,
   output sci_pkg::mem_req_type mem_req
);
   import sci_pkg::*;

   logic                 busy_ff, busy_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;

   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         addr_in = addr_ff + ADDR_BITS'(1);
         if (addr_ff == {ADDR_BITS{1'b1}}) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   always_comb begin
      mem_req         = '0;
      mem_req.wr_en   = busy_ff;
      mem_req.wr_addr = addr_ff;
   end

   assign busy = busy_ff;

endmodule

@@ sv/sci_core.sv @@
// Lookup and update sequencer: reads an entry, classifies the index and writes back.
`timescale 1ns / 1ps

module sci_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear_busy,
   input  logic [sci_pkg::COUNT_BITS-1:0]    vertex_count,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  sci_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sci_pkg::rsp_payload_type          rsp_payload,
   output sci_pkg::mem_req_type              mem_req,
   input  sci_pkg::entry_type                rd_entry
);
   import sci_pkg::*;

   core_state_type             state_ff, state_in;
   req_payload_type            item_ff, item_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_payload_ff, rsp_payload_in;
   logic [GENERATION_BITS-1:0] cur_gen_ff, cur_gen_in;
   logic [COUNT_BITS-1:0]      next_index_ff, next_index_in;
   logic                       exhausted_ff, exhausted_in;

   logic                       accept;
   logic                       finish;
   logic                       in_range;
   logic                       hit;
   logic [GENERATION_BITS-1:0] gen_plus;
   rsp_payload_type            result;
   logic                       write_new;

   assign req_ready = (state_ff == ST_IDLE) && !clear_busy;
   assign accept    = req_valid && req_ready;
   assign finish    = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ready);

   assign in_range = (COUNT_BITS'(item_ff.orig_index) < vertex_count) &&
                     (32'(item_ff.orig_index) < 32'(VERTEX_CAPACITY));
   assign hit      = (rd_entry.tag == cur_gen_ff);
   assign gen_plus = cur_gen_ff + GENERATION_BITS'(1);

   // Classify the held index against the entry read when the index was accepted.
   always_comb begin
      result                = '0;
      result.last           = item_ff.last_of_submesh;
      write_new             = 1'b0;
      if (exhausted_ff) begin
         result.status = STATUS_EXHAUSTED;
      end else if (!in_range) begin
         result.status = STATUS_RANGE;
      end else if (hit) begin
         result.status    = STATUS_REUSED;
         result.new_index = rd_entry.value;
      end else begin
         result.status         = STATUS_NEW;
         result.new_index      = next_index_ff[INDEX_BITS-1:0];
         result.vertex_to_copy = item_ff.orig_index;
         write_new             = 1'b1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      cur_gen_in     = cur_gen_ff;
      next_index_in  = next_index_ff;
      exhausted_in   = exhausted_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in  = req_payload;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (finish) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = result;
               state_in       = ST_IDLE;
               if (write_new) begin
                  next_index_in = next_index_ff + COUNT_BITS'(1);
               end
               // Closing a submesh restarts numbering and, unless exhausted, moves to a fresh generation.
               if (item_ff.last_of_submesh) begin
                  next_index_in = '0;
                  if (!exhausted_ff) begin
                     cur_gen_in = gen_plus;
                     if (gen_plus == '0) begin
                        exhausted_in = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cur_gen_ff    <= GENERATION_BITS'(1);
         next_index_ff <= '0;
         exhausted_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cur_gen_ff    <= cur_gen_in;
         next_index_ff <= next_index_in;
         exhausted_ff  <= exhausted_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_comb begin
      mem_req               = '0;
      mem_req.rd_en         = accept;
      mem_req.rd_addr       = ADDR_BITS'(req_payload.orig_index);
      mem_req.wr_en         = finish && write_new;
      mem_req.wr_addr       = ADDR_BITS'(item_ff.orig_index);
      mem_req.wr_data.tag   = cur_gen_ff;
      mem_req.wr_data.value = next_index_ff[INDEX_BITS-1:0];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ sv/submesh_index_compactor_top.sv @@
// Top level of the submesh index compactor: register, remap table and sequencer.
`timescale 1ns / 1ps
// Sequence: an accepted index has its table entry read into a register; then, in the lookup
// state, the index is classified, the result is registered and a new entry is written back.
// A result still waiting on the output holds the lookup state back. No new index is taken
// until the previous one has left the lookup state.
// Reset: after reset a clearing pass writes a zero tag into all VERTEX_CAPACITY entries;
// no index is accepted during it, while register writes are taken throughout.

module submesh_index_compactor_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sci_pkg::COUNT_BITS-1:0] csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  sci_pkg::req_payload_type       req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sci_pkg::rsp_payload_type       rsp_payload
);
   import sci_pkg::*;

   // The vertex count register. Any index at or above it is reported as out of range, unless exhausted.
   // It is always ready; writes must only arrive while the block is idle, which it does not enforce.
   logic [COUNT_BITS-1:0] vertex_count_ff, vertex_count_in;

   assign csr_ready       = 1'b1;
   assign vertex_count_in = (csr_valid && csr_ready) ? csr_data : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   // The clearing sweep owns the table port until every tag is zero. After that the
   // sequencer owns it. Because an item is fully written back before the next one is
   // read, a read never overlaps a pending write to the same entry.
   logic        clear_busy;
   mem_req_type clear_req;
   mem_req_type core_req;
   mem_req_type mem_req;
   entry_type   rd_entry;

   sci_clear u_clear (
      .clock   (clock),
      .reset   (reset),
      .busy    (clear_busy),
      .mem_req (clear_req)
   );

   sci_core u_core (
      .clock        (clock),
      .reset        (reset),
      .clear_busy   (clear_busy),
      .vertex_count (vertex_count_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .mem_req      (core_req),
      .rd_entry     (rd_entry)
   );

   assign mem_req = clear_busy ? clear_req : core_req;

   // One table holds both the generation tag and the remapped index of each source vertex.
   // A tag that differs from the current generation marks the entry as unused in this
   // submesh, so the index field is only trusted after a write in the same generation.
   sci_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (VERTEX_CAPACITY)
   ) u_table (
      .clock   (clock),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_entry),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data)
   );

endmodule
